### rtl/weight_stability_detector_assert.svh
// Assertion macros used by the weight stability detector checker
`ifndef WEIGHT_STABILITY_DETECTOR_ASSERT_SVH
`define WEIGHT_STABILITY_DETECTOR_ASSERT_SVH

// Check a property on every clock edge outside reset
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define WSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/wsd_pkg.sv
// Shared constants, types and microprogram of the weight stability detector
`default_nettype none

package wsd_pkg;

  // Field and storage sizes
  localparam int unsigned DataW     = 24;
  localparam int unsigned MaxWindow = 16;
  localparam int unsigned AddrW     = $clog2(MaxWindow);
  localparam int unsigned LenW      = $clog2(MaxWindow + 1);
  localparam int unsigned SumW      = DataW + AddrW;
  localparam int unsigned CntW      = $clog2(((SumW > MaxWindow) ? SumW : MaxWindow) + 1);
  localparam int unsigned DivW      = AddrW + 1;
  localparam int unsigned WinLenW   = 5;
  localparam int unsigned AbsW      = 24;
  localparam int unsigned RelW      = 10;
  localparam int unsigned ProdW     = DataW + RelW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned StepW     = 5;

  // Per-mille scale of the relative test
  localparam int unsigned PermilleScale = 1000;

  // Register values after reset
  localparam logic [WinLenW-1:0] WinLenReset = WinLenW'(16);
  localparam logic [AbsW-1:0]    AbsReset    = AbsW'(10);
  localparam logic [RelW-1:0]    RelReset    = RelW'(50);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_ABS_LIMIT     = 2'd1,
    CFG_REL_LIMIT     = 2'd2
  } cfg_idx_e;

  // Datapath operations of one microcode word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MARK_FULL,
    OP_STORE,
    OP_REDUCE,
    OP_EMIT_RAW,
    OP_EMIT_AVG,
    OP_CLEAR,
    OP_RELAVG,
    OP_ERR_SAMPLE,
    OP_SUM_INIT,
    OP_SUM_READ,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SET_AVG,
    OP_CHK_READ,
    OP_SET_BAL
  } op_e;

  // Jump conditions of one microcode word
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAL,
    C_FULL,
    C_FAIL,
    C_LOOP_MORE,
    C_DIV_MORE,
    C_TMP_GE_LEN,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic               accept;
    op_e                op;
    cond_e              cond;
    logic [StepW-1:0]   target;
  } ucode_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    op_e  op;
  } wsd_ctrl_t;

  // Status handed from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic balanced;
    logic full;
    logic fail;
    logic loop_more;
    logic div_more;
    logic tmp_ge_len;
  } wsd_status_t;

  // Program addresses
  localparam logic [StepW-1:0] StWait     = StepW'(0);
  localparam logic [StepW-1:0] StDispatch = StepW'(1);
  localparam logic [StepW-1:0] StFullTest = StepW'(2);
  localparam logic [StepW-1:0] StMarkFull = StepW'(3);
  localparam logic [StepW-1:0] StStore    = StepW'(4);
  localparam logic [StepW-1:0] StReduce   = StepW'(5);
  localparam logic [StepW-1:0] StEmitRaw  = StepW'(6);
  localparam logic [StepW-1:0] StRawDone  = StepW'(7);
  localparam logic [StepW-1:0] StBalRel   = StepW'(8);
  localparam logic [StepW-1:0] StBalErr   = StepW'(9);
  localparam logic [StepW-1:0] StBalCmp   = StepW'(10);
  localparam logic [StepW-1:0] StBalTest  = StepW'(11);
  localparam logic [StepW-1:0] StEmitAvg  = StepW'(12);
  localparam logic [StepW-1:0] StAvgDone  = StepW'(13);
  localparam logic [StepW-1:0] StBalClear = StepW'(14);
  localparam logic [StepW-1:0] StSumInit  = StepW'(15);
  localparam logic [StepW-1:0] StSumRead  = StepW'(16);
  localparam logic [StepW-1:0] StSumDrain = StepW'(17);
  localparam logic [StepW-1:0] StDivInit  = StepW'(18);
  localparam logic [StepW-1:0] StDivStep  = StepW'(19);
  localparam logic [StepW-1:0] StSetAvg   = StepW'(20);
  localparam logic [StepW-1:0] StChkRel   = StepW'(21);
  localparam logic [StepW-1:0] StChkRead  = StepW'(22);
  localparam logic [StepW-1:0] StChkErr   = StepW'(23);
  localparam logic [StepW-1:0] StChkCmp   = StepW'(24);
  localparam logic [StepW-1:0] StChkTest  = StepW'(25);
  localparam logic [StepW-1:0] StSetBal   = StepW'(26);

  // Build one microcode word
  function automatic ucode_t mk_word(input logic acc, input op_e op, input cond_e cond,
                                     input logic [StepW-1:0] target);
    ucode_t w;
    w.accept = acc;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: fall through to the next word unless the condition holds
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = mk_word(1'b0, OP_NOP, C_ALWAYS, StWait);
    unique case (step)
      StWait:     w = mk_word(1'b1, OP_LOAD,       C_NO_INPUT,   StWait);
      StDispatch: w = mk_word(1'b0, OP_NOP,        C_BAL,        StBalRel);
      StFullTest: w = mk_word(1'b0, OP_NOP,        C_FULL,       StSumInit);
      StMarkFull: w = mk_word(1'b0, OP_MARK_FULL,  C_NEVER,      StWait);
      StStore:    w = mk_word(1'b0, OP_STORE,      C_NEVER,      StWait);
      StReduce:   w = mk_word(1'b0, OP_REDUCE,     C_TMP_GE_LEN, StReduce);
      StEmitRaw:  w = mk_word(1'b0, OP_EMIT_RAW,   C_OUT_BUSY,   StEmitRaw);
      StRawDone:  w = mk_word(1'b0, OP_NOP,        C_ALWAYS,     StWait);
      StBalRel:   w = mk_word(1'b0, OP_RELAVG,     C_NEVER,      StWait);
      StBalErr:   w = mk_word(1'b0, OP_ERR_SAMPLE, C_NEVER,      StWait);
      StBalCmp:   w = mk_word(1'b0, OP_NOP,        C_NEVER,      StWait);
      StBalTest:  w = mk_word(1'b0, OP_NOP,        C_FAIL,       StBalClear);
      StEmitAvg:  w = mk_word(1'b0, OP_EMIT_AVG,   C_OUT_BUSY,   StEmitAvg);
      StAvgDone:  w = mk_word(1'b0, OP_NOP,        C_ALWAYS,     StWait);
      StBalClear: w = mk_word(1'b0, OP_CLEAR,      C_ALWAYS,     StStore);
      StSumInit:  w = mk_word(1'b0, OP_SUM_INIT,   C_NEVER,      StWait);
      StSumRead:  w = mk_word(1'b0, OP_SUM_READ,   C_LOOP_MORE,  StSumRead);
      StSumDrain: w = mk_word(1'b0, OP_NOP,        C_NEVER,      StWait);
      StDivInit:  w = mk_word(1'b0, OP_DIV_INIT,   C_NEVER,      StWait);
      StDivStep:  w = mk_word(1'b0, OP_DIV_STEP,   C_DIV_MORE,   StDivStep);
      StSetAvg:   w = mk_word(1'b0, OP_SET_AVG,    C_NEVER,      StWait);
      StChkRel:   w = mk_word(1'b0, OP_RELAVG,     C_NEVER,      StWait);
      StChkRead:  w = mk_word(1'b0, OP_CHK_READ,   C_LOOP_MORE,  StChkRead);
      StChkErr:   w = mk_word(1'b0, OP_NOP,        C_NEVER,      StWait);
      StChkCmp:   w = mk_word(1'b0, OP_NOP,        C_NEVER,      StWait);
      StChkTest:  w = mk_word(1'b0, OP_NOP,        C_FAIL,       StStore);
      StSetBal:   w = mk_word(1'b0, OP_SET_BAL,    C_ALWAYS,     StStore);
      default:    w = mk_word(1'b0, OP_NOP,        C_ALWAYS,     StWait);
    endcase
    return w;
  endfunction

  // Saturate the programmed window length into 2..MaxWindow
  function automatic logic [LenW-1:0] eff_len(input logic [WinLenW-1:0] wl);
    logic [LenW-1:0] n;
    if (int'(wl) < 2) begin
      n = LenW'(2);
    end else if (int'(wl) > int'(MaxWindow)) begin
      n = LenW'(MaxWindow);
    end else begin
      n = LenW'(wl);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/wsd_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module wsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/wsd_useq.sv
// Microcode sequencer: step counter, control store and jump logic
`default_nettype none

module wsd_useq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wsd_pkg::wsd_status_t status_i,
  output wsd_pkg::wsd_ctrl_t       ctrl_o
);

  logic [wsd_pkg::StepW-1:0] step_q, step_d;
  wsd_pkg::ucode_t           word;
  logic                      take;

  // Fetch the current control word
  assign word = wsd_pkg::ucode_rom(step_q);

  // Evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      wsd_pkg::C_NEVER:      take = 1'b0;
      wsd_pkg::C_ALWAYS:     take = 1'b1;
      wsd_pkg::C_NO_INPUT:   take = !status_i.in_valid;
      wsd_pkg::C_BAL:        take = status_i.balanced;
      wsd_pkg::C_FULL:       take = status_i.full;
      wsd_pkg::C_FAIL:       take = status_i.fail;
      wsd_pkg::C_LOOP_MORE:  take = status_i.loop_more;
      wsd_pkg::C_DIV_MORE:   take = status_i.div_more;
      wsd_pkg::C_TMP_GE_LEN: take = status_i.tmp_ge_len;
      wsd_pkg::C_OUT_BUSY:   take = status_i.out_busy;
      default:               take = 1'b0;
    endcase
  end

  // Jump or advance
  assign step_d = take ? word.target : step_q + wsd_pkg::StepW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= wsd_pkg::StWait;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.accept = word.accept;
  assign ctrl_o.op     = word.op;

endmodule

`default_nettype wire

### rtl/wsd_dpath.sv
// Datapath: window store, summing, serial divider, limit checks, result register
`default_nettype none

module wsd_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wsd_pkg::wsd_ctrl_t            ctrl_i,
  output wsd_pkg::wsd_status_t               status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wsd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wsd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic [wsd_pkg::DataW-1:0]     sample_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic      [wsd_pkg::DataW-1:0]     shown_value_o,
  output logic                               showing_average_o,
  output logic                               balanced_o
);

  // Configuration registers
  logic [wsd_pkg::WinLenW-1:0] win_len_q;
  logic [wsd_pkg::AbsW-1:0]    abs_q;
  logic [wsd_pkg::RelW-1:0]    rel_q;
  logic [wsd_pkg::LenW-1:0]    len_eff;

  // Control state
  logic [wsd_pkg::AddrW-1:0]   wi_q, wi_d;
  logic                        full_q, full_d;
  logic                        bal_q, bal_d;
  logic [wsd_pkg::DataW-1:0]   avg_q, avg_d;
  logic [wsd_pkg::MaxWindow-1:0] valid_q, valid_d;
  logic                        fail_q, fail_d;
  logic                        rd_sum_q, rd_sum_d;
  logic                        rd_chk_q, rd_chk_d;
  logic                        err_pend_q, err_pend_d;
  logic                        rvalid_q, rvalid_d;
  logic                        out_valid_q, out_valid_d;

  // Working registers
  logic [wsd_pkg::DataW-1:0]   sample_q, sample_d;
  logic [wsd_pkg::LenW-1:0]    tmp_q, tmp_d;
  logic [wsd_pkg::SumW-1:0]    acc_q, acc_d;
  logic [wsd_pkg::AddrW-1:0]   rem_q, rem_d;
  logic [wsd_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [wsd_pkg::ProdW-1:0]   relavg_q, relavg_d;
  logic [wsd_pkg::DataW-1:0]   err_q, err_d;
  logic [wsd_pkg::DataW-1:0]   shown_q, shown_d;
  logic                        show_avg_q, show_avg_d;
  logic                        bal_out_q, bal_out_d;

  // Combinational helpers
  logic [wsd_pkg::DataW-1:0]   ram_rdata;
  logic [wsd_pkg::DataW-1:0]   rd_data;
  logic [wsd_pkg::AddrW-1:0]   raddr;
  logic                        ram_we;
  logic [wsd_pkg::DataW-1:0]   err_src;
  logic [wsd_pkg::DataW-1:0]   err_calc;
  logic [wsd_pkg::ProdW-1:0]   err_scaled;
  logic                        err_fail;
  logic [wsd_pkg::DivW-1:0]    trial;
  logic                        trial_ge;
  logic                        out_busy;
  logic                        emit;
  logic                        loop_more;
  logic                        div_more;
  logic                        tmp_ge_len;

  assign len_eff = wsd_pkg::eff_len(win_len_q);

  // Hold configuration; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= wsd_pkg::WinLenReset;
      abs_q     <= wsd_pkg::AbsReset;
      rel_q     <= wsd_pkg::RelReset;
    end else if (cfg_we_i) begin
      unique case (wsd_pkg::cfg_idx_e'(cfg_idx_i))
        wsd_pkg::CFG_WINDOW_LENGTH: win_len_q <= cfg_data_i[wsd_pkg::WinLenW-1:0];
        wsd_pkg::CFG_ABS_LIMIT:     abs_q     <= cfg_data_i[wsd_pkg::AbsW-1:0];
        wsd_pkg::CFG_REL_LIMIT:     rel_q     <= cfg_data_i[wsd_pkg::RelW-1:0];
        default: ;
      endcase
    end
  end

  // Window store; entries without a valid bit read as zero
  assign raddr  = cnt_q[wsd_pkg::AddrW-1:0];
  assign ram_we = (ctrl_i.op == wsd_pkg::OP_STORE);

  wsd_ram #(
    .Width (wsd_pkg::DataW),
    .Depth (wsd_pkg::MaxWindow)
  ) u_wsd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (sample_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_data = rvalid_q ? ram_rdata : '0;

  // Absolute deviation from the held average
  assign err_src  = (ctrl_i.op == wsd_pkg::OP_ERR_SAMPLE) ? sample_q : rd_data;
  assign err_calc = (err_src >= avg_q) ? (err_src - avg_q) : (avg_q - err_src);

  // Limit tests on a registered deviation
  assign err_scaled = wsd_pkg::ProdW'(err_q) * wsd_pkg::ProdW'(wsd_pkg::PermilleScale);
  assign err_fail   = (err_q > abs_q) || (err_scaled > relavg_q);

  // Restoring divider, one quotient bit per step
  assign trial    = {rem_q, acc_q[wsd_pkg::SumW-1]};
  assign trial_ge = (trial >= wsd_pkg::DivW'(len_eff));

  // Loop tests for the sequencer
  assign loop_more  = ((wsd_pkg::CntW+1)'(cnt_q) + (wsd_pkg::CntW+1)'(1))
                      < (wsd_pkg::CntW+1)'(len_eff);
  assign div_more   = (cnt_q != wsd_pkg::CntW'(wsd_pkg::SumW - 1));
  assign tmp_ge_len = (tmp_q >= len_eff);

  assign out_busy = out_valid_q && out_stall_i;
  assign emit     = ((ctrl_i.op == wsd_pkg::OP_EMIT_RAW) ||
                     (ctrl_i.op == wsd_pkg::OP_EMIT_AVG)) && !out_busy;

  // Execute the current operation
  always_comb begin
    wi_d      = wi_q;
    full_d    = full_q;
    bal_d     = bal_q;
    avg_d     = avg_q;
    valid_d   = valid_q;
    fail_d    = fail_q;
    sample_d  = sample_q;
    tmp_d     = tmp_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    relavg_d  = relavg_q;

    // Accumulate or compare what the read pipeline delivers
    if (rd_sum_q) begin
      acc_d = acc_q + wsd_pkg::SumW'(rd_data);
    end
    if (err_pend_q && err_fail) begin
      fail_d = 1'b1;
    end

    unique case (ctrl_i.op) inside
      wsd_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          sample_d = sample_i;
        end
      end
      wsd_pkg::OP_MARK_FULL: begin
        if (wsd_pkg::LenW'(wi_q) + wsd_pkg::LenW'(1) == len_eff) begin
          full_d = 1'b1;
        end
      end
      wsd_pkg::OP_STORE: begin
        valid_d[wi_q] = 1'b1;
        tmp_d         = wsd_pkg::LenW'(wi_q) + wsd_pkg::LenW'(1);
      end
      wsd_pkg::OP_REDUCE: begin
        if (tmp_ge_len) begin
          tmp_d = tmp_q - len_eff;
        end else begin
          wi_d = tmp_q[wsd_pkg::AddrW-1:0];
        end
      end
      wsd_pkg::OP_CLEAR: begin
        valid_d = '0;
        wi_d    = '0;
        full_d  = 1'b0;
        bal_d   = 1'b0;
        avg_d   = '0;
      end
      wsd_pkg::OP_RELAVG: begin
        fail_d   = 1'b0;
        cnt_d    = '0;
        relavg_d = wsd_pkg::ProdW'(rel_q) * wsd_pkg::ProdW'(avg_q);
      end
      wsd_pkg::OP_SUM_INIT: begin
        acc_d = '0;
        cnt_d = '0;
      end
      wsd_pkg::OP_SUM_READ, wsd_pkg::OP_CHK_READ: begin
        cnt_d = cnt_q + wsd_pkg::CntW'(1);
      end
      wsd_pkg::OP_DIV_INIT: begin
        rem_d = '0;
        cnt_d = '0;
      end
      wsd_pkg::OP_DIV_STEP: begin
        if (trial_ge) begin
          rem_d = wsd_pkg::AddrW'(trial - wsd_pkg::DivW'(len_eff));
        end else begin
          rem_d = trial[wsd_pkg::AddrW-1:0];
        end
        acc_d = {acc_q[wsd_pkg::SumW-2:0], trial_ge};
        cnt_d = cnt_q + wsd_pkg::CntW'(1);
      end
      wsd_pkg::OP_SET_AVG: begin
        avg_d = acc_q[wsd_pkg::DataW-1:0];
      end
      wsd_pkg::OP_SET_BAL: begin
        bal_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Track reads in flight and deviations waiting for the compare
  assign rd_sum_d   = (ctrl_i.op == wsd_pkg::OP_SUM_READ);
  assign rd_chk_d   = (ctrl_i.op == wsd_pkg::OP_CHK_READ);
  assign err_pend_d = (ctrl_i.op == wsd_pkg::OP_ERR_SAMPLE) || rd_chk_q;
  assign rvalid_d   = valid_q[raddr];
  assign err_d      = err_pend_d ? err_calc : err_q;

  // Load the result register, drop it when taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    shown_d     = shown_q;
    show_avg_d  = show_avg_q;
    bal_out_d   = bal_out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      bal_out_d   = bal_q;
      if (ctrl_i.op == wsd_pkg::OP_EMIT_AVG) begin
        shown_d    = avg_q;
        show_avg_d = 1'b1;
      end else begin
        shown_d    = sample_q;
        show_avg_d = 1'b0;
      end
    end
  end

  // Control state flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q        <= '0;
      full_q      <= 1'b0;
      bal_q       <= 1'b0;
      avg_q       <= '0;
      valid_q     <= '0;
      fail_q      <= 1'b0;
      rd_sum_q    <= 1'b0;
      rd_chk_q    <= 1'b0;
      err_pend_q  <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wi_q        <= wi_d;
      full_q      <= full_d;
      bal_q       <= bal_d;
      avg_q       <= avg_d;
      valid_q     <= valid_d;
      fail_q      <= fail_d;
      rd_sum_q    <= rd_sum_d;
      rd_chk_q    <= rd_chk_d;
      err_pend_q  <= err_pend_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload flops
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    tmp_q      <= tmp_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    relavg_q   <= relavg_d;
    err_q      <= err_d;
    shown_q    <= shown_d;
    show_avg_q <= show_avg_d;
    bal_out_q  <= bal_out_d;
  end

  assign status_o.in_valid   = in_valid_i;
  assign status_o.out_busy   = out_busy;
  assign status_o.balanced   = bal_q;
  assign status_o.full       = full_q;
  assign status_o.fail       = fail_q;
  assign status_o.loop_more  = loop_more;
  assign status_o.div_more   = div_more;
  assign status_o.tmp_ge_len = tmp_ge_len;

  assign out_valid_o       = out_valid_q;
  assign shown_value_o     = shown_q;
  assign showing_average_o = show_avg_q;
  assign balanced_o        = bal_out_q;

endmodule

`default_nettype wire

### rtl/weight_stability_detector.sv
// A request takes the short path while filling or for a sample that keeps the balance, the
// longer one for a sample that breaks it; the reduce step repeats per extra index wrap after a length cut.
// A full, unbalanced window is processed in order: one read per entry to sum, a 28-step
// serial divider, one read per entry.
// Requests are handled one at a time; the next is taken only after the result is loaded.
// Reset: asynchronous, active low; clears flags, index, valid bits; length 16, 10, 50 permille.
`default_nettype none

module weight_stability_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wsd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wsd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wsd_pkg::DataW-1:0]     sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [wsd_pkg::DataW-1:0]     shown_value_o,
  output logic                               showing_average_o,
  output logic                               balanced_o
);

  wsd_pkg::wsd_ctrl_t   ctrl;
  wsd_pkg::wsd_status_t status;

  // Sequence the microprogram
  wsd_useq u_wsd_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Run the datapath
  wsd_dpath u_wsd_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .sample_i          (sample_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .shown_value_o     (shown_value_o),
    .showing_average_o (showing_average_o),
    .balanced_o        (balanced_o)
  );

  // Take a request only in the wait step
  assign in_stall_o = !ctrl.accept;

endmodule

`default_nettype wire

### rtl/wsd_checker.sv
// Port-level checker for the weight stability detector and its bind
`default_nettype none

`include "weight_stability_detector_assert.svh"

module wsd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic showing_average_o,
  input wire logic balanced_o
);

  // A stalled result stays offered
  `WSD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // The held average is shown only in the balanced state
  `WSD_ASSERT(a_avg_bal, out_valid_o && showing_average_o |-> balanced_o, "average shown unbalanced")

  // One request at a time: stall right after taking one
  `WSD_ASSERT(a_one_req, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken early")

  // No result during reset
  `WSD_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind weight_stability_detector wsd_checker u_wsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .showing_average_o (showing_average_o),
  .balanced_o        (balanced_o)
);

`default_nettype wire
